### hdl/modexp_pkg.sv
`default_nettype none
package modexp_pkg;

   localparam int WIDTH_DEFAULT = 32;
   localparam int MODULUS_RESET = 23;

   // top -> core
   typedef struct packed {
      logic start;   // word accepted on the request side
      logic take;    // result moves into the output register
   } core_ctl_type;

   // core -> top
   typedef struct packed {
      logic idle;    // ready for a new word
      logic done;    // result held, waiting to be taken
   } core_sts_type;

endpackage
`default_nettype wire

### hdl/modexp_req_if.sv
`default_nettype none
interface modexp_req_if #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] base_value;
   logic [WIDTH-1:0] exponent_value;

   modport source (output valid, output base_value, output exponent_value, input ready);
   modport sink   (input valid, input base_value, input exponent_value, output ready);
endinterface
`default_nettype wire

### hdl/modexp_rsp_if.sv
`default_nettype none
interface modexp_rsp_if #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] power_result;

   modport source (output valid, output power_result, input ready);
   modport sink   (input valid, input power_result, output ready);
endinterface
`default_nettype wire

### hdl/modular_exponentiation.sv
`default_nettype none
// Channel   Dir  Fields                        Handshake
// req_chan  in   base_value, exponent_value    valid/ready
// rsp_chan  out  power_result                  valid/ready
// csr_*     in   modulus                       write enable, no wait
//
// With a zero exponent the word goes straight to a result of 1; otherwise base
// reduction comes first, then per exponent bit one multiply (square) plus one
// more when the bit is set, each multiply a double-and-add run on the shared
// modular adder.
// req_chan.ready is high only while the sequencer is idle; a finished result waits
// in the sequencer until the output register is free. Sync reset sets modulus 23.
module modular_exponentiation #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   modexp_req_if.sink            req_chan,
   modexp_rsp_if.source          rsp_chan,
   input  wire logic             csr_write_enable,
   input  wire logic [WIDTH-1:0] csr_write_data
);
   logic [WIDTH-1:0]          modulus_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]          rsp_data_ff, rsp_data_in;
   logic [WIDTH-1:0]          core_result;
   modexp_pkg::core_ctl_type  core_ctl;
   modexp_pkg::core_sts_type  core_sts;

   modexp_core #(.WIDTH(WIDTH)) u_core (
      .clock          (clock),
      .reset          (reset),
      .ctl            (core_ctl),
      .modulus        (modulus_ff),
      .base_value     (req_chan.base_value),
      .exponent_value (req_chan.exponent_value),
      .sts            (core_sts),
      .power_result   (core_result)
   );

   always_comb begin
      core_ctl.start = req_chan.valid && core_sts.idle;
      core_ctl.take  = core_sts.done && (!rsp_valid_ff || rsp_chan.ready);
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      if (core_ctl.take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= WIDTH'(modexp_pkg::MODULUS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            modulus_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready        = core_sts.idle;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.power_result = rsp_data_ff;

`ifndef SYNTHESIS
   // an accepted word keeps the sequencer busy next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("sequencer idle right after accepting a word");

   // a new result only comes from a held sequencer result
   a_rsp_from_core: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(core_sts.done))
      else $error("response valid without a finished result");

   // a result not taken stays held
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (core_sts.done && !core_ctl.take) |=> core_sts.done)
      else $error("result dropped before transfer");
`endif
endmodule
`default_nettype wire

### hdl/modexp_addmod.sv
`default_nettype none
// s = (u + v + cin) mod m, for u, v < m; a zero modulus wraps at WIDTH bits.
module modexp_addmod #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
   input  wire logic [WIDTH-1:0] u,
   input  wire logic [WIDTH-1:0] v,
   input  wire logic             cin,
   input  wire logic [WIDTH-1:0] m,
   output logic      [WIDTH-1:0] s
);
   logic [WIDTH:0] sum;
   logic [WIDTH:0] diff;
   logic           ge;

   always_comb begin
      sum  = {1'b0, u} + {1'b0, v} + {{WIDTH{1'b0}}, cin};
      diff = sum - {1'b0, m};
      ge   = (sum >= {1'b0, m});
      if ((m != '0) && ge) begin
         s = diff[WIDTH-1:0];
      end else begin
         s = sum[WIDTH-1:0];
      end
   end
endmodule
`default_nettype wire

### hdl/modexp_core.sv
`default_nettype none
// Sequencer around one shared modular adder: base reduction by shift-subtract,
// then square-and-multiply where each multiply is double-and-add over the bits.
module modexp_core #(
   parameter int WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire modexp_pkg::core_ctl_type   ctl,
   input  wire logic [WIDTH-1:0]           modulus,
   input  wire logic [WIDTH-1:0]           base_value,
   input  wire logic [WIDTH-1:0]           exponent_value,
   output modexp_pkg::core_sts_type        sts,
   output logic [WIDTH-1:0]                power_result
);
   localparam int CW = $clog2(WIDTH);
   localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_MDBL   = 3'd2;
   localparam logic [2:0] ST_MADD   = 3'd3;
   localparam logic [2:0] ST_HOLD   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    ecnt_ff, ecnt_in;
   logic             sq_ff, sq_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] prod_ff, prod_in;
   logic [WIDTH-1:0] mx_ff, mx_in;
   logic [WIDTH-1:0] my_ff, my_in;

   logic [WIDTH-1:0] op_u, op_v, sum;
   logic             op_cin;
   logic [WIDTH-1:0] one_mod;

   modexp_addmod #(.WIDTH(WIDTH)) u_addmod (
      .u   (op_u),
      .v   (op_v),
      .cin (op_cin),
      .m   (modulus),
      .s   (sum)
   );

   always_comb begin
      // 1 mod m: only a modulus of one changes it
      one_mod = (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);

      op_u   = prod_ff;
      op_v   = prod_ff;
      op_cin = 1'b0;
      unique case (state_ff)
         ST_REDUCE: begin
            op_u   = rem_ff;
            op_v   = rem_ff;
            op_cin = base_ff[WIDTH-1];
         end
         ST_MADD: begin
            op_v = mx_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ecnt_in  = ecnt_ff;
      sq_in    = sq_ff;
      exp_in   = exp_ff;
      base_in  = base_ff;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               if (exponent_value == '0) begin
                  acc_in   = WIDTH'(1);
                  state_in = ST_HOLD;
               end else begin
                  base_in  = base_value;
                  rem_in   = '0;
                  exp_in   = exponent_value;
                  acc_in   = one_mod;
                  cnt_in   = LAST;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            rem_in  = sum;
            base_in = base_ff << 1;
            if (cnt_ff == '0) begin
               base_in  = sum;
               mx_in    = acc_ff;
               my_in    = acc_ff;
               prod_in  = '0;
               cnt_in   = LAST;
               ecnt_in  = LAST;
               sq_in    = 1'b1;
               state_in = ST_MDBL;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_MDBL, ST_MADD: begin
            prod_in = sum;
            if ((state_ff == ST_MDBL) && my_ff[WIDTH-1]) begin
               state_in = ST_MADD;
            end else begin
               my_in = my_ff << 1;
               if (cnt_ff != '0) begin
                  cnt_in   = cnt_ff - CW'(1);
                  state_in = ST_MDBL;
               end else begin
                  // one modular multiply finished
                  acc_in  = sum;
                  prod_in = '0;
                  cnt_in  = LAST;
                  if (sq_ff && exp_ff[WIDTH-1]) begin
                     mx_in    = base_ff;
                     my_in    = sum;
                     sq_in    = 1'b0;
                     state_in = ST_MDBL;
                  end else begin
                     exp_in = exp_ff << 1;
                     if (ecnt_ff == '0) begin
                        state_in = ST_HOLD;
                     end else begin
                        ecnt_in  = ecnt_ff - CW'(1);
                        mx_in    = sum;
                        my_in    = sum;
                        sq_in    = 1'b1;
                        state_in = ST_MDBL;
                     end
                  end
               end
            end
         end
         ST_HOLD: begin
            if (ctl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff  <= cnt_in;
      ecnt_ff <= ecnt_in;
      sq_ff   <= sq_in;
      exp_ff  <= exp_in;
      base_ff <= base_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
   end

   assign sts.idle     = (state_ff == ST_IDLE);
   assign sts.done     = (state_ff == ST_HOLD);
   assign power_result = acc_ff;
endmodule
`default_nettype wire
